// ----- hw/rtl/idiv_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer divider package
// Shared types and constants for the iterative signed and unsigned divider.
// ----------------------------------------------------------------------------
package idiv_pkg;

  localparam int unsigned XLEN = 64;

  typedef enum logic {
    OP_UNSIGNED,
    OP_SIGNED
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG_N,
    ST_NEG_D,
    ST_DIV,
    ST_NEG_Q,
    ST_NEG_R,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    STEP_HOLD,
    STEP_NEG_N,
    STEP_NEG_D,
    STEP_DIV,
    STEP_NEG_Q,
    STEP_NEG_R
  } step_e;

  typedef struct packed {
    logic  load;
    step_e step;
  } ctrl_t;

endpackage

// ----- hw/rtl/idiv_if.sv -----
// ----------------------------------------------------------------------------
// Integer divider channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface idiv_req_if import idiv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [XLEN-1:0] numerator;
  logic [XLEN-1:0] denominator;
  logic            opcode;

  modport source (output valid, numerator, denominator, opcode, input ready);
  modport sink   (input valid, numerator, denominator, opcode, output ready);
endinterface

interface idiv_rsp_if import idiv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [XLEN-1:0] quotient;
  logic [XLEN-1:0] remainder;

  modport source (output valid, quotient, remainder, input ready);
  modport sink   (input valid, quotient, remainder, output ready);
endinterface

// ----- hw/rtl/idiv_ctrl.sv -----
// ----------------------------------------------------------------------------
// Integer divider sequencer
// Steps the shared subtractor through operand negation, one quotient bit per
// cycle and the final sign correction.
// ----------------------------------------------------------------------------
module idiv_ctrl import idiv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  out_free_i,
  output logic  out_load_o,
  output ctrl_t ctrl_o
);

  localparam int unsigned CW = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] LAST_BIT = CW'(DATA_WIDTH - 1);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_NEG_N;
        end
      end
      ST_NEG_N: state_d = ST_NEG_D;
      ST_NEG_D: begin
        state_d = ST_DIV;
        cnt_d   = LAST_BIT;
      end
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_NEG_Q;
        end
      end
      ST_NEG_Q: state_d = ST_NEG_R;
      ST_NEG_R: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_load_o  = 1'b0;
    ctrl_o.load = 1'b0;
    ctrl_o.step = STEP_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_NEG_N: ctrl_o.step = STEP_NEG_N;
      ST_NEG_D: ctrl_o.step = STEP_NEG_D;
      ST_DIV:   ctrl_o.step = STEP_DIV;
      ST_NEG_Q: ctrl_o.step = STEP_NEG_Q;
      ST_NEG_R: ctrl_o.step = STEP_NEG_R;
      ST_DONE:  out_load_o  = out_free_i;
      default:  ctrl_o.step = STEP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/idiv_datapath.sv -----
// ----------------------------------------------------------------------------
// Integer divider datapath
// Operand, remainder and quotient registers around one shared subtractor.
// ----------------------------------------------------------------------------
module idiv_datapath import idiv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  ctrl_t                 ctrl_i,
  input  logic [XLEN-1:0]       numerator_i,
  input  logic [XLEN-1:0]       denominator_i,
  input  logic                  opcode_i,
  output logic [DATA_WIDTH-1:0] quotient_o,
  output logic [DATA_WIDTH-1:0] remainder_o
);

  localparam int unsigned W = DATA_WIDTH;

  // The dividend register shifts out numerator bits and takes in quotient bits.
  logic [W-1:0] a_q, a_d;
  logic [W-1:0] d_q, d_d;
  logic [W-1:0] r_q, r_d;
  logic         neg_n_q, neg_n_d;
  logic         neg_d_q, neg_d_d;
  logic         dz_q, dz_d;

  logic [W-1:0] num;
  logic [W-1:0] den;
  logic         is_signed;
  logic [W:0]   op_a;
  logic [W:0]   op_b;
  logic [W:0]   diff;

  assign num       = numerator_i[W-1:0];
  assign den       = denominator_i[W-1:0];
  assign is_signed = (opcode_e'(opcode_i) == OP_SIGNED);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctrl_i.step)
      STEP_NEG_N: op_b = {1'b0, a_q};
      STEP_NEG_D: op_b = {1'b0, d_q};
      STEP_DIV: begin
        op_a = {r_q, a_q[W-1]};
        op_b = {1'b0, d_q};
      end
      STEP_NEG_Q: op_b = {1'b0, a_q};
      STEP_NEG_R: op_b = {1'b0, r_q};
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff = op_a - op_b;

  always_comb begin
    a_d     = a_q;
    d_d     = d_q;
    r_d     = r_q;
    neg_n_d = neg_n_q;
    neg_d_d = neg_d_q;
    dz_d    = dz_q;
    if (ctrl_i.load) begin
      a_d     = num;
      d_d     = den;
      r_d     = '0;
      dz_d    = (den == '0);
      neg_n_d = is_signed && num[W-1] && (den != '0);
      neg_d_d = is_signed && den[W-1] && (den != '0);
    end else begin
      unique case (ctrl_i.step)
        STEP_NEG_N: begin
          if (neg_n_q) begin
            a_d = diff[W-1:0];
          end
        end
        STEP_NEG_D: begin
          if (neg_d_q) begin
            d_d = diff[W-1:0];
          end
        end
        STEP_DIV: begin
          if (!dz_q) begin
            a_d = {a_q[W-2:0], ~diff[W]};
            r_d = diff[W] ? op_a[W-1:0] : diff[W-1:0];
          end
        end
        STEP_NEG_Q: begin
          if (neg_n_q ^ neg_d_q) begin
            a_d = diff[W-1:0];
          end
        end
        STEP_NEG_R: begin
          if (neg_n_q) begin
            r_d = diff[W-1:0];
          end
        end
        default: a_d = a_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    d_q     <= d_d;
    r_q     <= r_d;
    neg_n_q <= neg_n_d;
    neg_d_q <= neg_d_d;
    dz_q    <= dz_d;
  end

  assign quotient_o  = dz_q ? '0 : a_q;
  assign remainder_o = dz_q ? a_q : r_q;

endmodule

// ----- hw/rtl/int64_divider_signed_unsigned.sv -----
// ----------------------------------------------------------------------------
// Signed and unsigned integer divider
// Restoring binary long division returning both quotient and remainder.
// ----------------------------------------------------------------------------
// One item is taken at a time and yields one result holding the quotient and
// the remainder of the low DATA_WIDTH bits of the operands; higher result bits
// are zero. After an item is accepted, the sequencer negates any negative
// operand in signed mode and passes it through otherwise, takes each quotient
// bit through the shared subtractor, corrects the signs and then loads the
// output register once that register is free.
// The request side is ready again once the result sits in the output
// register, so a new item may be accepted while that result still waits to
// be taken. Division by zero gives a quotient of zero and returns the
// numerator as the remainder; the most negative value divided by minus one
// wraps to itself with a zero remainder.
module int64_divider_signed_unsigned import idiv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  idiv_req_if.sink          req_i,
  idiv_rsp_if.source        rsp_o
);

  ctrl_t                 ctrl;
  logic                  out_free;
  logic                  out_load;
  logic [DATA_WIDTH-1:0] dp_quotient;
  logic [DATA_WIDTH-1:0] dp_remainder;
  logic                  out_valid_q;
  logic [XLEN-1:0]       quotient_q;
  logic [XLEN-1:0]       remainder_q;

  assign out_free = !out_valid_q || rsp_o.ready;

  idiv_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .ctrl_o     (ctrl)
  );

  idiv_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .numerator_i   (req_i.numerator),
    .denominator_i (req_i.denominator),
    .opcode_i      (req_i.opcode),
    .quotient_o    (dp_quotient),
    .remainder_o   (dp_remainder)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      quotient_q  <= XLEN'(dp_quotient);
      remainder_q <= XLEN'(dp_remainder);
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.quotient  = quotient_q;
  assign rsp_o.remainder = remainder_q;

  // An accepted item keeps the request side closed on the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready
  ) else $error("divider ready again straight after accepting an item");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || rsp_o.ready)
  ) else $error("divider result overwritten before it was taken");

  // A result only appears after the sequencer has loaded it.
  a_valid_from_load: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(out_load)
  ) else $error("divider result valid without a load");

endmodule
